[rtl/ordered_value_list_engine_unit_assert.svh]
// Assertion macros for the list engine RTL.
`ifndef ORDERED_VALUE_LIST_ENGINE_UNIT_ASSERT_SVH
`define ORDERED_VALUE_LIST_ENGINE_UNIT_ASSERT_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define OVLE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("list engine check failed");

// Next-cycle implication, checked on every clock edge outside reset.
`define OVLE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("list engine check failed");

`endif

[rtl/ovle_pkg.sv]
// Types and constants for the ordered value list engine.
package ovle_pkg;

  localparam int CAPACITY = 64;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int VALUE_W = 32;
  localparam int ENTRY_COUNT_W = 7;

  typedef enum logic [2:0] {
    CMD_PUSH   = 3'd0,
    CMD_POP    = 3'd1,
    CMD_EXISTS = 3'd2,
    CMD_REM_LT = 3'd3,
    CMD_REM_EQ = 3'd4,
    CMD_REM_GT = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    SH_HOLD,
    SH_PUSH,
    SH_PULL
  } shift_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_APPLY
  } state_e;

  typedef struct packed {
    logic [2:0]                 command;
    logic signed [VALUE_W-1:0]  key_value;
  } in_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0]  popped_value;
    logic                       hit;
    logic                       error;
    logic [ENTRY_COUNT_W-1:0]   entry_count;
  } out_t;

  // Control broadcast from the sequencer to every cell of the row.
  typedef struct packed {
    logic                       load_match;
    shift_e                     op;
    logic [2:0]                 cmd;
    logic signed [VALUE_W-1:0]  key;
  } ctl_t;

endpackage

[rtl/ordered_value_list_engine_unit.sv]
// Ordered value list engine: a row of compare-and-shift cells under a small sequencer.
//
// Commands arrive on in_valid/in_ready/in_data (command, key_value); one result per
// command leaves on out_valid/out_ready/out_data (popped_value, hit, error, entry_count).
// A command is taken only while the sequencer is idle. An accepted command enters an eval
// step, in which every cell compares its value with the key and stores a match flag; then
// the apply step, once the output register is free, locates the first match across the row,
// shifts the cells toward the front or the back in one step and writes the result and
// out_valid to the output register. Only then does the sequencer return to idle, so for every
// command alike a new command is taken only once the previous one has written its result.
// The output register holds one result. While it is full and out_ready is low, the
// sequencer waits in its apply step and takes no new command; nothing is lost.
// Reset (rst_n low at a rising edge) empties the list and clears out_valid. Cell
// contents are not cleared: only positions below the count are ever read.
module ordered_value_list_engine_unit (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  ovle_pkg::in_t   in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output ovle_pkg::out_t  out_data
);

  `include "ordered_value_list_engine_unit_assert.svh"

  localparam int CAP = ovle_pkg::CAPACITY;
  localparam int CNT_W = ovle_pkg::CNT_W;
  localparam int ECW = ovle_pkg::ENTRY_COUNT_W;

  ovle_pkg::state_e                      state_r, state_nxt;
  logic [2:0]                            cmd_r;
  logic signed [ovle_pkg::VALUE_W-1:0]   key_r;
  logic [CNT_W-1:0]                      count_r, count_nxt;
  ovle_pkg::out_t                        out_r, out_nxt;
  logic                                  out_valid_r;
  logic                                  apply_fire;
  ovle_pkg::ctl_t                        ctl;

  logic signed [ovle_pkg::VALUE_W-1:0]   values [CAP];
  logic [CAP-1:0]                        match_vec;
  logic [CAP-1:0]                        occ_vec;
  logic [CAP-1:0]                        pull_vec;
  logic [CAP-1:0]                        match_dec;
  logic [CAP-1:0]                        from_first;
  logic                                  any_match;

  // Cell row. Lower index is nearer the front of the list.
  for (genvar i = 0; i < CAP; i++) begin : g_cell
    logic signed [ovle_pkg::VALUE_W-1:0] left_v;
    logic signed [ovle_pkg::VALUE_W-1:0] right_v;

    if (i == 0) begin : g_head
      assign left_v = key_r;
    end else begin : g_body
      assign left_v = values[i-1];
    end

    if (i == CAP - 1) begin : g_tail
      assign right_v = values[i];
    end else begin : g_inner
      assign right_v = values[i+1];
    end

    assign occ_vec[i] = count_r > CNT_W'(i);

    ovle_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .occupied    (occ_vec[i]),
      .pull_sel    (pull_vec[i]),
      .left_value  (left_v),
      .right_value (right_v),
      .value       (values[i]),
      .match       (match_vec[i])
    );
  end

  // Cells at and behind the first match: clear the bits below the lowest set bit.
  assign match_dec  = match_vec - CAP'(1);
  assign from_first = ~(match_vec ^ match_dec) | (match_vec & ~match_dec);
  assign any_match  = |match_vec;

  assign apply_fire = (state_r == ovle_pkg::ST_APPLY) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    ctl.load_match = 1'b0;
    ctl.op         = ovle_pkg::SH_HOLD;
    ctl.cmd        = cmd_r;
    ctl.key        = key_r;
    pull_vec       = '0;
    out_nxt        = out_r;

    case (state_r)
      ovle_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ovle_pkg::ST_EVAL;
        end
      end
      ovle_pkg::ST_EVAL: begin
        ctl.load_match = 1'b1;
        state_nxt      = ovle_pkg::ST_APPLY;
      end
      ovle_pkg::ST_APPLY: begin
        if (apply_fire) begin
          state_nxt            = ovle_pkg::ST_IDLE;
          out_nxt.popped_value = '0;
          out_nxt.hit          = 1'b0;
          out_nxt.error        = 1'b0;
          case (ovle_pkg::cmd_e'(cmd_r))
            ovle_pkg::CMD_PUSH: begin
              if (count_r == CNT_W'(CAP)) begin
                out_nxt.error = 1'b1;
              end else begin
                ctl.op    = ovle_pkg::SH_PUSH;
                count_nxt = count_r + CNT_W'(1);
              end
            end
            ovle_pkg::CMD_POP: begin
              if (count_r == '0) begin
                out_nxt.error = 1'b1;
              end else begin
                out_nxt.popped_value = values[0];
                ctl.op               = ovle_pkg::SH_PULL;
                pull_vec             = '1;
                count_nxt            = count_r - CNT_W'(1);
              end
            end
            ovle_pkg::CMD_EXISTS: begin
              out_nxt.hit = any_match;
            end
            ovle_pkg::CMD_REM_LT, ovle_pkg::CMD_REM_EQ, ovle_pkg::CMD_REM_GT: begin
              if (any_match) begin
                out_nxt.hit = 1'b1;
                ctl.op      = ovle_pkg::SH_PULL;
                pull_vec    = from_first;
                count_nxt   = count_r - CNT_W'(1);
              end
            end
            default: begin
            end
          endcase
          out_nxt.entry_count = ECW'(count_nxt);
        end
      end
      default: state_nxt = ovle_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ovle_pkg::ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (apply_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd_r <= in_data.command;
      key_r <= in_data.key_value;
    end
    out_r <= out_nxt;
  end

  assign in_ready  = state_r == ovle_pkg::ST_IDLE;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `OVLE_ASSERT_IMP(a_count_bound, 1'b1, count_r <= CNT_W'(CAP))
  `OVLE_ASSERT_NXT(a_error_keeps_count, apply_fire && out_nxt.error, $stable(count_r))
  `OVLE_ASSERT_IMP(a_hit_error_excl, out_valid_r, !(out_r.hit && out_r.error))
  `OVLE_ASSERT_IMP(a_result_count, $rose(out_valid_r), out_r.entry_count == ECW'(count_r))
  `OVLE_ASSERT_IMP(a_no_accept_busy, out_valid_r && !out_ready && state_r == ovle_pkg::ST_APPLY,
                   !apply_fire)

endmodule

[rtl/ovle_cell.sv]
// One storage cell of the list: holds a value, compares it with the key and shifts.
module ovle_cell (
  input  logic                                 clk,
  input  ovle_pkg::ctl_t                       ctl,
  input  logic                                 occupied,
  input  logic                                 pull_sel,
  input  logic signed [ovle_pkg::VALUE_W-1:0]  left_value,
  input  logic signed [ovle_pkg::VALUE_W-1:0]  right_value,
  output logic signed [ovle_pkg::VALUE_W-1:0]  value,
  output logic                                 match
);

  logic signed [ovle_pkg::VALUE_W-1:0] value_r;
  logic                                match_r;
  logic                                cmp_hit;

  always_comb begin
    case (ovle_pkg::cmd_e'(ctl.cmd))
      ovle_pkg::CMD_REM_LT: cmp_hit = $signed(value_r) < $signed(ctl.key);
      ovle_pkg::CMD_REM_GT: cmp_hit = $signed(value_r) > $signed(ctl.key);
      default:              cmp_hit = value_r == ctl.key;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctl.load_match) begin
      match_r <= occupied && cmp_hit;
    end
    case (ctl.op)
      ovle_pkg::SH_PUSH: value_r <= left_value;
      ovle_pkg::SH_PULL: begin
        if (pull_sel) begin
          value_r <= right_value;
        end
      end
      default: value_r <= value_r;
    endcase
  end

  assign value = value_r;
  assign match = match_r;

endmodule

[tb/tb_top.sv]
// Self-checking testbench for the ordered value list engine with a queue-based list tracker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Codes outside the defined command set; the block must report them as no-ops.
  localparam logic [2:0] CMD_SPARE6 = 3'd6;
  localparam logic [2:0] CMD_SPARE7 = 3'd7;
  localparam logic signed [ovle_pkg::VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [ovle_pkg::VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam int LIMIT_CYCLES = 200000;
  localparam int LONG_HOLD = 300;

  class list_tracker;
    logic signed [ovle_pkg::VALUE_W-1:0] values[$];
    ovle_pkg::out_t awaited[$];
    int failures;

    function new();
      failures = 0;
    endfunction

    // Applies one accepted command to the tracked list and queues its result.
    function void take_command(ovle_pkg::in_t item);
      ovle_pkg::out_t res;
      logic signed [ovle_pkg::VALUE_W-1:0] key;
      logic sel;
      res = '0;
      key = item.key_value;
      case (item.command)
        ovle_pkg::CMD_PUSH: begin
          if (values.size() >= ovle_pkg::CAPACITY) res.error = 1'b1;
          else values.push_front(key);
        end
        ovle_pkg::CMD_POP: begin
          if (values.size() == 0) res.error = 1'b1;
          else res.popped_value = values.pop_front();
        end
        ovle_pkg::CMD_EXISTS: begin
          foreach (values[i]) if (values[i] == key) res.hit = 1'b1;
        end
        ovle_pkg::CMD_REM_LT, ovle_pkg::CMD_REM_EQ, ovle_pkg::CMD_REM_GT: begin
          // Only the first match from the front is deleted.
          for (int i = 0; i < values.size() && !res.hit; i++) begin
            case (item.command)
              ovle_pkg::CMD_REM_LT: sel = values[i] < key;
              ovle_pkg::CMD_REM_EQ: sel = values[i] == key;
              default:              sel = values[i] > key;
            endcase
            if (sel) begin
              values.delete(i);
              res.hit = 1'b1;
            end
          end
        end
        default: ;
      endcase
      res.entry_count = ovle_pkg::ENTRY_COUNT_W'(values.size());
      awaited.push_back(res);
    endfunction

    function void check_result(ovle_pkg::out_t got);
      ovle_pkg::out_t want;
      if (awaited.size() == 0) begin
        $error("result with no command outstanding: %p", got);
        failures++;
      end else begin
        want = awaited.pop_front();
        if (got.popped_value !== want.popped_value) begin
          $error("popped_value: expected %0d, actual %0d",
                 $signed(want.popped_value), $signed(got.popped_value));
          failures++;
        end
        if (got.hit !== want.hit) begin
          $error("hit: expected %0d, actual %0d", want.hit, got.hit);
          failures++;
        end
        if (got.error !== want.error) begin
          $error("error: expected %0d, actual %0d", want.error, got.error);
          failures++;
        end
        if (got.entry_count !== want.entry_count) begin
          $error("entry_count: expected %0d, actual %0d", want.entry_count, got.entry_count);
          failures++;
        end
      end
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function int depth();
      return values.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  ovle_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  ovle_pkg::out_t out_data;

  list_tracker tracker = new();
  int sent = 0;

  always #6 clk = ~clk;

  ordered_value_list_engine_unit DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  // Random command; keys mostly come from a small pool so that searches and removes hit.
  function automatic ovle_pkg::in_t pick_item(int push_pct, int pop_pct);
    ovle_pkg::in_t item;
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < push_pct) item.command = ovle_pkg::CMD_PUSH;
    else if (roll < push_pct + pop_pct) item.command = ovle_pkg::CMD_POP;
    else item.command = ovle_pkg::CMD_EXISTS + 3'($urandom_range(0, 3));
    roll = $urandom_range(0, 9);
    if (roll < 7) item.key_value = 32'($urandom_range(0, 8)) - 32'd4;
    else if (roll == 7) item.key_value = $urandom_range(0, 1) ? VAL_MAX : VAL_MIN;
    else item.key_value = $urandom();
    return item;
  endfunction

  task automatic offer(ovle_pkg::in_t item);
    int gap;
    gap = ((sent / 32) % 4 == 3) ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (!in_ready);
    tracker.take_command(item);
    sent++;
  endtask

  // Result side: a random stall after each transaction outside stall-free stretches, plus one long hold-off.
  initial begin : receiver
    int stall_left;
    int seen;
    stall_left = 0;
    seen = 0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        tracker.check_result(out_data);
        seen++;
        stall_left = ((seen / 40) % 3 == 1) ? 0 : $urandom_range(0, 5);
        if (seen == 120) stall_left = LONG_HOLD;
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_ready <= (stall_left == 0);
    end
  end

  initial begin : watchdog
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("Some tests failed");
    $finish;
  end

  initial begin : stimulus
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Empty list: every command up to the first push must leave it untouched.
    offer('{ovle_pkg::CMD_POP, 32'sd0});
    offer('{ovle_pkg::CMD_REM_LT, 32'sd0});
    offer('{ovle_pkg::CMD_REM_EQ, 32'sd0});
    offer('{ovle_pkg::CMD_REM_GT, 32'sd0});
    offer('{ovle_pkg::CMD_EXISTS, 32'sd0});
    offer('{CMD_SPARE6, 32'sd1});
    offer('{CMD_SPARE7, -32'sd1});
    offer('{ovle_pkg::CMD_PUSH, VAL_MAX});
    offer('{ovle_pkg::CMD_PUSH, VAL_MIN});
    offer('{ovle_pkg::CMD_PUSH, 32'sd0});
    offer('{ovle_pkg::CMD_PUSH, -32'sd1});
    offer('{ovle_pkg::CMD_PUSH, 32'sd5});
    offer('{ovle_pkg::CMD_EXISTS, VAL_MAX});
    offer('{ovle_pkg::CMD_EXISTS, 32'sd7});
    // The front element matches here, so only it goes.
    offer('{ovle_pkg::CMD_REM_GT, 32'sd0});
    offer('{ovle_pkg::CMD_REM_LT, VAL_MIN});
    offer('{ovle_pkg::CMD_REM_GT, VAL_MAX});
    offer('{ovle_pkg::CMD_REM_EQ, VAL_MIN});
    offer('{ovle_pkg::CMD_REM_LT, 32'sd0});
    offer('{CMD_SPARE7, 32'sd3});
    offer('{ovle_pkg::CMD_POP, 32'sd0});
    offer('{ovle_pkg::CMD_POP, 32'sd0});
    offer('{ovle_pkg::CMD_POP, 32'sd0});

    // Fill to capacity and push past it, then drain to empty and pop past it.
    repeat (2) begin
      while (tracker.depth() < ovle_pkg::CAPACITY) offer(pick_item(85, 5));
      repeat (6) offer(pick_item(85, 5));
      while (tracker.depth() > 0) offer(pick_item(5, 55));
      repeat (6) offer(pick_item(5, 55));
    end
    repeat (50) offer(pick_item(30, 15));
    in_valid <= 1'b0;

    while (tracker.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (tracker.failures == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
